// File: rtl/core/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared constants and types for the triangle plane clipper.
// ----------------------------------------------------------------------------
package tpc_pkg;

  // fraction bits of the edge parameter t
  localparam int T_FRAC = 24;

  // threshold register width
  localparam int THR_W = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_PLANE_NX = 3'd0;
  localparam cfg_idx_t REG_PLANE_NY = 3'd1;
  localparam cfg_idx_t REG_PLANE_NZ = 3'd2;
  localparam cfg_idx_t REG_POINT_X  = 3'd3;
  localparam cfg_idx_t REG_POINT_Y  = 3'd4;
  localparam cfg_idx_t REG_POINT_Z  = 3'd5;
  localparam cfg_idx_t REG_THRESH   = 3'd6;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/core/tpc_mul.sv
// ----------------------------------------------------------------------------
// tpc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module tpc_mul #(
  parameter int A_W = 33,
  parameter int B_W = 26
) (
  input  logic                        clk,
  input  logic signed [A_W-1:0]       op_a,
  input  logic signed [B_W-1:0]       op_b,
  output logic signed [A_W+B_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= (A_W+B_W)'(op_a) * (A_W+B_W)'(op_b);
  end

endmodule

// File: rtl/core/tpc_div.sv
// ----------------------------------------------------------------------------
// tpc_div
// Radix-2 restoring divider: T_FRAC quotient bits of num/den, num < den.
// ----------------------------------------------------------------------------
module tpc_div #(
  parameter int W = 52
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [W-1:0]                num,
  input  logic [W-1:0]                den,
  output tpc_pkg::div_stat_t          stat,
  output logic [tpc_pkg::T_FRAC-1:0]  q_r
);

  localparam int CNT_W = $clog2(tpc_pkg::T_FRAC + 1);

  logic [W:0]       rem_r;
  logic [W-1:0]     den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [W:0]       shifted;
  logic             ge;
  logic [W:0]       rem_nxt;

  always_comb begin
    shifted = {rem_r[W-1:0], 1'b0};
    ge      = shifted >= {1'b0, den_r};
    rem_nxt = ge ? (shifted - {1'b0, den_r}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= {1'b0, num};
        den_r  <= den;
        q_r    <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[tpc_pkg::T_FRAC-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(tpc_pkg::T_FRAC - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: rtl/core/triangle_plane_clipper_core.sv
// ----------------------------------------------------------------------------
// triangle_plane_clipper_core
// Clips each triangle of a vertex stream against a configured plane.
//
//  channel | dir | payload                                   | handshake
//  --------+-----+-------------------------------------------+--------------
//  in_*    | in  | tdata: pos x,y,z, norm x,y,z              | tvalid/tready
//  out_*   | out | tdata: x,y,z, norm x,y,z; tuser; tlast    | tvalid/tready
//  cfg_*   | in  | index + data, 7 registers                 | cfg_we only
//
// First and second corner of a triangle are stored in place. Third corner:
// plane distances (9 products on the shared multiplier, each a multiply and
// an accumulate step), a case decode, then per new corner setup (difference,
// check, range), the bit-per-cycle divider and interpolation on the shared
// multiplier, then one emitted item per cycle while out_tready allows it.
// in_tready is low from the third corner until emission is done.
// rst_n is synchronous; it resets control and configuration registers only.
// A stalled out_tready holds the output register and the emit step.
// ----------------------------------------------------------------------------
module triangle_plane_clipper_core #(
  parameter int COORD_WIDTH  = 32,
  parameter int NORMAL_WIDTH = 16,
  localparam int FIELD_BITS  = 3 * COORD_WIDTH + 3 * NORMAL_WIDTH,
  localparam int DATA_W      = ((FIELD_BITS + 7) / 8) * 8,
  localparam int CFG_W       = (COORD_WIDTH > NORMAL_WIDTH) ?
                               ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) :
                               ((NORMAL_WIDTH > 16) ? NORMAL_WIDTH : 16)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z (lowest bits first)
  input  logic [DATA_W-1:0]               in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // out_x, out_y, out_z, out_norm_x, out_norm_y, out_norm_z
  output logic [DATA_W-1:0]               out_tdata,
  // [0] is_intersection, [1] triangle_end
  output logic [1:0]                      out_tuser,
  output logic                            out_tlast,  // run_last
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_W-1:0]                cfg_wdata
);

  localparam int CW    = COORD_WIDTH;
  localparam int NW    = NORMAL_WIDTH;
  localparam int TF    = tpc_pkg::T_FRAC;
  localparam int MA    = ((CW > NW) ? CW : NW) + 1;
  localparam int MB    = (NW > TF + 2) ? NW : TF + 2;
  localparam int PW    = MA + MB;
  localparam int DWID  = CW + NW + 4;   // distance, num and den
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (TF - 1);
  localparam logic [TF:0] T_ONE = (TF+1)'(1) << TF;

  typedef enum logic [3:0] {
    S_IDLE, S_CLS_MUL, S_CLS_ACC, S_PLAN, S_CUT_DIFF, S_CUT_CHK,
    S_CUT_RANGE, S_CUT_DIV, S_LERP_MUL, S_LERP_ACC, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    SRC_C0, SRC_C1, SRC_C2, SRC_X0, SRC_X1
  } src_t;

  // configuration
  logic signed [NW-1:0]          pn_r [0:2];
  logic signed [CW-1:0]          pt_r [0:2];
  logic [tpc_pkg::THR_W-1:0]     thr_r;

  // corners and distances
  logic signed [CW-1:0]          pos_r [0:2][0:2];
  logic signed [NW-1:0]          nrm_r [0:2][0:2];
  logic signed [DWID-1:0]        d_r   [0:2];
  logic signed [DWID-1:0]        dacc_r;

  // new corners
  logic signed [CW-1:0]          xp_r [0:1][0:2];
  logic signed [NW-1:0]          xn_r [0:1][0:2];
  logic [1:0]                    cu_r [0:1];
  logic [1:0]                    cw_r [0:1];
  logic [1:0]                    ncut_r;
  logic signed [DWID-1:0]        num_r, den_r;
  logic [TF:0]                   t_r;

  // emission plan
  src_t                          plan_r [0:5];
  logic [2:0]                    nout_r;

  // sequencer
  state_t                        state_r;
  logic [1:0]                    cnt_r;
  logic [1:0]                    k_r;
  logic [2:0]                    a_r;
  logic [2:0]                    e_r;

  // output register
  logic                          out_valid_r;
  logic signed [CW-1:0]          ox_r, oy_r, oz_r;
  logic signed [NW-1:0]          onx_r, ony_r, onz_r;
  logic                          oisect_r, otri_r, olast_r;

  // shared units
  logic signed [MA-1:0]          mul_a;
  logic signed [MB-1:0]          mul_b;
  logic signed [PW-1:0]          mul_p;
  logic                          div_start;
  tpc_pkg::div_stat_t            div_stat;
  logic [TF-1:0]                 div_q;

  // combinational helpers
  logic [DWID-1:0]               thr_s;
  logic [1:0]                    ax;
  logic signed [MA-1:0]          u_val, w_val;
  logic signed [PW-1:0]          lerp_res;
  logic signed [DWID-1:0]        dacc_nxt;
  logic [2:0]                    on_c, bk_c;
  logic [1:0]                    nb, no;
  logic [1:0]                    pi, pj, pl, pf;
  src_t                          plan_nxt [0:5];
  logic [2:0]                    nout_nxt;
  logic [1:0]                    ncut_nxt;
  logic [1:0]                    cu_nxt [0:1];
  logic [1:0]                    cw_nxt [0:1];
  logic                          deg;
  logic                          in_acc;
  logic                          emit_go;
  logic                          emit_last;
  src_t                          esrc;
  logic signed [CW-1:0]          epx, epy, epz;
  logic signed [NW-1:0]          enx, eny, enz;

  function automatic logic [1:0] nxt3(input logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

  function automatic logic [DWID-1:0] abs_d(input logic signed [DWID-1:0] v);
    return v[DWID-1] ? DWID'(-v) : DWID'(v);
  endfunction

  tpc_mul #(.A_W(MA), .B_W(MB)) u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_p)
  );

  tpc_div #(.W(DWID)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .stat  (div_stat),
    .q_r   (div_q)
  );

  // --------------------------------------------------------------------------
  // configuration registers; unknown indexes are dropped
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pn_r[0] <= '0;
      pn_r[1] <= '0;
      pn_r[2] <= NW'(1) <<< (NW - 2);
      pt_r[0] <= '0;
      pt_r[1] <= '0;
      pt_r[2] <= '0;
      thr_r   <= tpc_pkg::THR_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        tpc_pkg::REG_PLANE_NX: pn_r[0] <= cfg_wdata[NW-1:0];
        tpc_pkg::REG_PLANE_NY: pn_r[1] <= cfg_wdata[NW-1:0];
        tpc_pkg::REG_PLANE_NZ: pn_r[2] <= cfg_wdata[NW-1:0];
        tpc_pkg::REG_POINT_X:  pt_r[0] <= cfg_wdata[CW-1:0];
        tpc_pkg::REG_POINT_Y:  pt_r[1] <= cfg_wdata[CW-1:0];
        tpc_pkg::REG_POINT_Z:  pt_r[2] <= cfg_wdata[CW-1:0];
        tpc_pkg::REG_THRESH:   thr_r   <= cfg_wdata[tpc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // on-plane limit in distance units
  assign thr_s = DWID'(thr_r) << (NW - 2);

  // --------------------------------------------------------------------------
  // multiplier operands: distance products, then interpolation products
  // --------------------------------------------------------------------------
  always_comb begin
    ax    = (a_r < 3'd3) ? a_r[1:0] : 2'(a_r - 3'd3);
    if (a_r < 3'd3) begin
      u_val = MA'(pos_r[cu_r[k_r[0]]][ax]);
      w_val = MA'(pos_r[cw_r[k_r[0]]][ax]);
    end else begin
      u_val = MA'(nrm_r[cu_r[k_r[0]]][ax]);
      w_val = MA'(nrm_r[cw_r[k_r[0]]][ax]);
    end
    if (state_r == S_LERP_MUL) begin
      mul_a = w_val - u_val;
      mul_b = MB'($signed({1'b0, t_r}));
    end else begin
      mul_a = MA'(pos_r[k_r][ax]) - MA'(pt_r[ax]);
      mul_b = MB'(pn_r[ax]);
    end
    // round half up, then add the start corner
    lerp_res = ((mul_p + HALF) >>> TF) + PW'(u_val);
    dacc_nxt = dacc_r + DWID'(mul_p);
  end

  // --------------------------------------------------------------------------
  // case decode from the three distances
  // --------------------------------------------------------------------------
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      on_c[c] = abs_d(d_r[c]) < thr_s;
      bk_c[c] = !on_c[c] && d_r[c][DWID-1];
    end
    nb = 2'(bk_c[0]) + 2'(bk_c[1]) + 2'(bk_c[2]);
    no = 2'(on_c[0]) + 2'(on_c[1]) + 2'(on_c[2]);
    for (int m = 0; m < 6; m++) plan_nxt[m] = SRC_C0;
    nout_nxt  = 3'd0;
    ncut_nxt  = 2'd0;
    cu_nxt[0] = 2'd0;
    cu_nxt[1] = 2'd0;
    cw_nxt[0] = 2'd0;
    cw_nxt[1] = 2'd0;
    pi = bk_c[0] ? 2'd0 : (bk_c[1] ? 2'd1 : 2'd2);
    pf = !bk_c[0] ? 2'd0 : (!bk_c[1] ? 2'd1 : 2'd2);
    pj = nxt3(pi);
    pl = nxt3(pj);
    priority if ((3'(nb) + 3'(no)) == 3'd3) begin
      // fully behind or on the plane: dropped
      nout_nxt = 3'd0;
    end else if (nb == 2'd0) begin
      plan_nxt[0] = SRC_C0;
      plan_nxt[1] = SRC_C1;
      plan_nxt[2] = SRC_C2;
      nout_nxt    = 3'd3;
    end else if (nb == 2'd1) begin
      if (no == 2'd0) begin
        // split into two triangles
        cu_nxt[0] = pi;  cw_nxt[0] = pj;
        cu_nxt[1] = pi;  cw_nxt[1] = pl;
        plan_nxt[0] = SRC_X0;
        plan_nxt[1] = src_t'({1'b0, pj});
        plan_nxt[2] = src_t'({1'b0, pl});
        plan_nxt[3] = SRC_X0;
        plan_nxt[4] = src_t'({1'b0, pl});
        plan_nxt[5] = SRC_X1;
        nout_nxt    = 3'd6;
        ncut_nxt    = 2'd2;
      end else begin
        // one corner on the plane: slide the behind corner to the front one
        cu_nxt[0] = pi;
        cw_nxt[0] = on_c[pj] ? pl : pj;
        for (int m = 0; m < 3; m++)
          plan_nxt[m] = (2'(m) == pi) ? SRC_X0 : src_t'(3'(m));
        nout_nxt = 3'd3;
        ncut_nxt = 2'd1;
      end
    end else begin
      // two behind: shrink toward the front corner
      cu_nxt[0] = nxt3(nxt3(pf));  cw_nxt[0] = pf;
      cu_nxt[1] = nxt3(pf);        cw_nxt[1] = pf;
      plan_nxt[0] = SRC_X0;
      plan_nxt[1] = src_t'({1'b0, pf});
      plan_nxt[2] = SRC_X1;
      nout_nxt    = 3'd3;
      ncut_nxt    = 2'd2;
    end
  end

  // --------------------------------------------------------------------------
  // emit source select
  // --------------------------------------------------------------------------
  always_comb begin
    esrc = plan_r[e_r];
    unique case (esrc)
      SRC_X0, SRC_X1: begin
        epx = xp_r[esrc == SRC_X1][0];
        epy = xp_r[esrc == SRC_X1][1];
        epz = xp_r[esrc == SRC_X1][2];
        enx = xn_r[esrc == SRC_X1][0];
        eny = xn_r[esrc == SRC_X1][1];
        enz = xn_r[esrc == SRC_X1][2];
      end
      default: begin
        epx = pos_r[esrc[1:0]][0];
        epy = pos_r[esrc[1:0]][1];
        epz = pos_r[esrc[1:0]][2];
        enx = nrm_r[esrc[1:0]][0];
        eny = nrm_r[esrc[1:0]][1];
        enz = nrm_r[esrc[1:0]][2];
      end
    endcase
  end

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_tready);
  assign emit_last = (e_r == nout_r - 3'd1);
  assign deg       = (abs_d(num_r) < thr_s) || (abs_d(den_r) < thr_s);
  assign div_start = (state_r == S_CUT_RANGE) && (num_r > 0) && (num_r < den_r);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 2'd0;
      k_r         <= 2'd0;
      a_r         <= 3'd0;
      e_r         <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      // a new item loads while the old one drains, else drop on handshake
      if (emit_go) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            for (int c = 0; c < 3; c++) begin
              pos_r[cnt_r][c] <= in_tdata[c*CW +: CW];
              nrm_r[cnt_r][c] <= in_tdata[3*CW + c*NW +: NW];
            end
            if (cnt_r == 2'd2) begin
              cnt_r   <= 2'd0;
              k_r     <= 2'd0;
              a_r     <= 3'd0;
              dacc_r  <= '0;
              state_r <= S_CLS_MUL;
            end else begin
              cnt_r <= cnt_r + 2'd1;
            end
          end
        end
        S_CLS_MUL: state_r <= S_CLS_ACC;
        S_CLS_ACC: begin
          if (a_r == 3'd2) begin
            d_r[k_r] <= dacc_nxt;
            dacc_r   <= '0;
            a_r      <= 3'd0;
            if (k_r == 2'd2) begin
              state_r <= S_PLAN;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= S_CLS_MUL;
            end
          end else begin
            dacc_r  <= dacc_nxt;
            a_r     <= a_r + 3'd1;
            state_r <= S_CLS_MUL;
          end
        end
        S_PLAN: begin
          for (int m = 0; m < 6; m++) plan_r[m] <= plan_nxt[m];
          nout_r <= nout_nxt;
          ncut_r <= ncut_nxt;
          cu_r[0] <= cu_nxt[0];
          cu_r[1] <= cu_nxt[1];
          cw_r[0] <= cw_nxt[0];
          cw_r[1] <= cw_nxt[1];
          k_r <= 2'd0;
          e_r <= 3'd0;
          priority if (nout_nxt == 3'd0) state_r <= S_IDLE;
          else if (ncut_nxt == 2'd0)     state_r <= S_EMIT;
          else                           state_r <= S_CUT_DIFF;
        end
        S_CUT_DIFF: begin
          num_r   <= -d_r[cu_r[k_r[0]]];
          den_r   <= d_r[cw_r[k_r[0]]] - d_r[cu_r[k_r[0]]];
          a_r     <= 3'd0;
          state_r <= S_CUT_CHK;
        end
        S_CUT_CHK: begin
          if (deg) begin
            t_r     <= '0;
            state_r <= S_LERP_MUL;
          end else begin
            if (den_r[DWID-1]) begin
              num_r <= -num_r;
              den_r <= -den_r;
            end
            state_r <= S_CUT_RANGE;
          end
        end
        S_CUT_RANGE: begin
          priority if (num_r <= 0) begin
            t_r     <= '0;
            state_r <= S_LERP_MUL;
          end else if (num_r >= den_r) begin
            t_r     <= T_ONE;
            state_r <= S_LERP_MUL;
          end else begin
            state_r <= S_CUT_DIV;
          end
        end
        S_CUT_DIV: begin
          if (div_stat.done) begin
            t_r     <= {1'b0, div_q};
            state_r <= S_LERP_MUL;
          end
        end
        S_LERP_MUL: state_r <= S_LERP_ACC;
        S_LERP_ACC: begin
          if (a_r < 3'd3) xp_r[k_r[0]][ax] <= lerp_res[CW-1:0];
          else            xn_r[k_r[0]][ax] <= lerp_res[NW-1:0];
          if (a_r == 3'd5) begin
            if (k_r + 2'd1 < ncut_r) begin
              k_r     <= k_r + 2'd1;
              state_r <= S_CUT_DIFF;
            end else begin
              state_r <= S_EMIT;
            end
          end else begin
            a_r     <= a_r + 3'd1;
            state_r <= S_LERP_MUL;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            ox_r        <= epx;
            oy_r        <= epy;
            oz_r        <= epz;
            onx_r       <= enx;
            ony_r       <= eny;
            onz_r       <= enz;
            oisect_r    <= (esrc == SRC_X0) || (esrc == SRC_X1);
            otri_r      <= (e_r == 3'd2) || (e_r == 3'd5);
            olast_r     <= emit_last;
            e_r         <= e_r + 3'd1;
            if (emit_last) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tdata  = DATA_W'({onz_r, ony_r, onx_r, oz_r, oy_r, ox_r});
  assign out_tuser  = {otri_r, oisect_r};
  assign out_tlast  = olast_r;
  assign out_tvalid = out_valid_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_last_ends_tri: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[1])
    else $error("run end without triangle end");

  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (num_r > 0) && (num_r < den_r) && !div_stat.busy)
    else $error("divider started out of range");

  a_t_sat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LERP_MUL |-> t_r <= T_ONE)
    else $error("edge parameter above one");

  a_third_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && cnt_r == 2'd2 |=> state_r == S_CLS_MUL && !in_tready)
    else $error("third corner did not start clipping");

endmodule
